// File: sv/dda_pkg.sv
// Shared types and constants for the DDA step-pulse generator.
package dda_pkg;

    localparam int STEP_W     = 8;   // width of a queued step count
    localparam int LEN_W      = 12;  // width of the frame length
    localparam int POS_W      = 13;  // width of the frame position
    localparam int ACC_W      = 13;  // width of the accumulator
    localparam int ACT_STEP_W = 4;   // width of the clamped active step

    localparam logic [LEN_W-1:0]      FRAME_LENGTH_RESET = LEN_W'(10);
    localparam logic [ACT_STEP_W-1:0] STEP_CLAMP         = ACT_STEP_W'(10);
    localparam logic [ACC_W-1:0]      ACC_MAX            = ACC_W'(8191);

    // Action codes carried by an input beat.
    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_PUSH = 1'b1;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // A classified command as it travels from the front to the back.
    typedef struct packed {
        logic              is_push;
        logic              running;
        logic [STEP_W-1:0] value;
    } cmd_t;

    // Occupancy of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: sv/dda_front.sv
// Front part: accepts input beats and classifies them into commands.
module dda_front
(
    input  logic                     action,
    input  logic                     enable,
    input  logic                     preset,
    input  logic [dda_pkg::STEP_W-1:0] step_value,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     cmd_valid,
    output dda_pkg::cmd_t            cmd,
    input  logic                     cmd_ready
);

    // A tick runs the prescaler only with enable set and preset clear.
    always_comb
    begin
        cmd.is_push = (action == dda_pkg::ACTION_PUSH);
        cmd.running = enable & ~preset;
        cmd.value   = step_value;
    end

    assign cmd_valid = in_valid;
    assign in_ready  = cmd_ready;

endmodule

// File: sv/dda_cmd_queue.sv
// Short command queue that decouples the front part from the back part.
module dda_cmd_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  dda_pkg::cmd_t        wr_cmd,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output dda_pkg::cmd_t        rd_cmd,
    output dda_pkg::q_status_t   status
);

    dda_pkg::cmd_t                 entry_reg [dda_pkg::QUEUE_DEPTH];
    logic [dda_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dda_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dda_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_wr;
    logic                          do_rd;

    assign status.full  = (count_reg == dda_pkg::QCNT_W'(dda_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    assign wr_ready = ~status.full;
    assign rd_valid = ~status.empty;
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    assign do_wr = wr_valid & wr_ready;
    assign do_rd = rd_valid & rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: sv/dda_back.sv
// Back part: prescaler, frame counter, step FIFO, accumulator and result register.
module dda_back
#(
    parameter int FIFO_DEPTH    = 10,
    parameter int PRESCALE_WRAP = 100
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [dda_pkg::LEN_W-1:0]        frame_length,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  dda_pkg::cmd_t                    cmd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pulse_out,
    output logic                             frame_flag,
    output logic                             clock_marker,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]  fifo_level
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int PC_W  = $clog2(PRESCALE_WRAP + 1);

    localparam logic [PC_W:0]      PC_WRAP_X = (PC_W+1)'(PRESCALE_WRAP);
    localparam logic [PC_W-1:0]    PC_WRAP   = PC_W'(PRESCALE_WRAP);
    localparam logic [PC_W-1:0]    PC_HALF   = PC_W'(PRESCALE_WRAP / 2);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(FIFO_DEPTH);

    localparam int STEP_W = dda_pkg::STEP_W;
    localparam int LEN_W  = dda_pkg::LEN_W;
    localparam int POS_W  = dda_pkg::POS_W;
    localparam int ACC_W  = dda_pkg::ACC_W;
    localparam int AS_W   = dda_pkg::ACT_STEP_W;

    logic                 out_valid_reg, out_valid_next;
    logic [PC_W-1:0]      prescale_reg, prescale_next;
    logic                 low_phase_reg, low_phase_next;
    logic                 marker_reg, marker_next;
    logic                 pending_reg, pending_next;
    logic                 pulse_reg, pulse_next;
    logic                 flag_reg, flag_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [AS_W-1:0]      step_reg, step_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [STEP_W-1:0]    fifo_reg  [FIFO_DEPTH];
    logic [STEP_W-1:0]    fifo_next [FIFO_DEPTH];

    logic                 exec;
    logic                 tick;
    logic                 push;
    logic [PC_W:0]        pc_inc;
    logic [PC_W-1:0]      pc_new;
    logic [POS_W-1:0]     pos_inc;
    logic [POS_W-1:0]     len_x;
    logic [POS_W-1:0]     twice_old;
    logic [POS_W-1:0]     twice_new;
    logic                 pop;
    logic [STEP_W-1:0]    head;
    logic [AS_W-1:0]      head_clamped;
    logic [ACC_W:0]       sum;
    logic [ACC_W-1:0]     sum_sat;
    logic [CNT_W-1:0]     count_push;
    logic [IDX_W-1:0]     wr_idx;

    assign exec      = cmd_valid & (~out_valid_reg | out_ready);
    assign cmd_ready = ~out_valid_reg | out_ready;
    assign tick      = exec & ~cmd.is_push;
    assign push      = exec & cmd.is_push;

    always_comb
    begin
        // Prescaler and marker
        pc_inc         = {1'b0, prescale_reg} + 1'b1;
        pc_new         = (pc_inc > PC_WRAP_X) ? '0 : pc_inc[PC_W-1:0];
        prescale_next  = prescale_reg;
        low_phase_next = low_phase_reg;
        marker_next    = marker_reg;
        pulse_next     = pulse_reg;
        if (tick)
        begin
            if (cmd.running)
            begin
                prescale_next  = pc_new;
                low_phase_next = (pc_new <= PC_HALF);
                if (pc_new == PC_HALF)
                begin
                    marker_next = 1'b1;
                end
                else if (pc_new == PC_WRAP)
                begin
                    marker_next = 1'b0;
                end
                pulse_next = ~low_phase_next & pending_reg;
            end
            else
            begin
                pulse_next  = 1'b0;
                marker_next = 1'b0;
            end
        end

        // Frame position and pop points
        pos_inc   = position_reg + 1'b1;
        len_x     = {1'b0, length_reg};
        twice_old = {length_reg, 1'b0};
        pop       = tick & ((pos_inc == len_x) | (pos_inc == twice_old));
        length_next = pop ? frame_length : length_reg;
        twice_new   = {length_next, 1'b0};
        head         = (count_reg != '0) ? fifo_reg[0] : '0;
        head_clamped = (head > STEP_W'(dda_pkg::STEP_CLAMP)) ? dda_pkg::STEP_CLAMP
                                                              : head[AS_W-1:0];
        step_next    = pop ? head_clamped : step_reg;

        position_next = position_reg;
        flag_next     = flag_reg;
        if (tick)
        begin
            flag_next     = (pos_inc <= len_x);
            position_next = (pos_inc >= twice_new) ? '0 : pos_inc;
        end

        // Accumulator: add, saturate, then take off one modulus on overflow
        sum     = {1'b0, acc_reg} + (ACC_W+1)'(step_next);
        sum_sat = (sum > {1'b0, dda_pkg::ACC_MAX}) ? dda_pkg::ACC_MAX : sum[ACC_W-1:0];
        acc_next     = acc_reg;
        pending_next = pending_reg;
        if (tick)
        begin
            if (sum_sat >= {1'b0, length_next})
            begin
                acc_next     = sum_sat - {1'b0, length_next};
                pending_next = 1'b1;
            end
            else
            begin
                acc_next     = sum_sat;
                pending_next = 1'b0;
            end
        end

        // Step FIFO as a shift line; a push to a full FIFO overwrites the tail.
        count_push = (count_reg < CNT_FULL) ? count_reg + 1'b1 : count_reg;
        wr_idx     = IDX_W'(count_push - 1'b1);
        count_next = count_reg;
        if (push)
        begin
            count_next = count_push;
        end
        else if (pop && (count_reg != '0))
        begin
            count_next = count_reg - 1'b1;
        end

        for (int j = 0; j < FIFO_DEPTH; j++)
        begin
            fifo_next[j] = fifo_reg[j];
            if (push && (wr_idx == IDX_W'(j)))
            begin
                fifo_next[j] = cmd.value;
            end
        end
        if (pop)
        begin
            for (int j = 0; j < FIFO_DEPTH - 1; j++)
            begin
                fifo_next[j] = fifo_reg[j+1];
            end
            fifo_next[FIFO_DEPTH-1] = '0;
        end

        // Result register
        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prescale_reg  <= '0;
            low_phase_reg <= 1'b0;
            marker_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            pulse_reg     <= 1'b0;
            flag_reg      <= 1'b0;
            position_reg  <= '0;
            length_reg    <= dda_pkg::FRAME_LENGTH_RESET;
            step_reg      <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            for (int j = 0; j < FIFO_DEPTH; j++)
            begin
                fifo_reg[j] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            prescale_reg  <= prescale_next;
            low_phase_reg <= low_phase_next;
            marker_reg    <= marker_next;
            pending_reg   <= pending_next;
            pulse_reg     <= pulse_next;
            flag_reg      <= flag_next;
            position_reg  <= position_next;
            length_reg    <= length_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            for (int j = 0; j < FIFO_DEPTH; j++)
            begin
                fifo_reg[j] <= fifo_next[j];
            end
        end
    end

    // The result fields are the state registers themselves: they change only
    // when an item executes, so a push item repeats the last tick's pulse, flag and marker.
    assign out_valid    = out_valid_reg;
    assign pulse_out    = pulse_reg;
    assign frame_flag   = flag_reg;
    assign clock_marker = marker_reg;
    assign fifo_level   = count_reg;

endmodule

// File: sv/dda_step_pulse_generator.sv
// Top level of the DDA step-pulse generator.
//
// Usage. Input beats arrive on in_valid/in_ready. A beat with action set
// pushes step_value into the step FIFO; a beat with action clear is one
// tick of the step clock, sampling enable and preset. Every input beat
// gives exactly one result beat on out_valid/out_ready carrying pulse_out,
// frame_flag, clock_marker and fifo_level; a push beat repeats the last
// tick's pulse, flag and marker alongside the new FIFO level.
// The frame length register is written on cfg_valid/cfg_ready (always
// ready) and should be written only while the block is idle. It takes
// effect at the next pop point of the frame.
// An accepted input beat is registered first in the command queue and then
// in the back part's result register. Throughput is one beat per cycle while
// the receiver keeps taking results, set by the back part's update of its
// state. In a steady stream the two-entry queue holds one beat, so when
// the receiver stalls it takes one further beat, fills and in_ready falls;
// in_ready rises again in the cycle after the waiting result is taken.
// After reset the frame length is ten, all counters and the FIFO are clear
// and no result is pending.
module dda_step_pulse_generator
#(
    parameter int FIFO_DEPTH    = 10,
    parameter int PRESCALE_WRAP = 100
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic                              enable,
    input  logic                              preset,
    input  logic [dda_pkg::STEP_W-1:0]        step_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pulse_out,
    output logic                              frame_flag,
    output logic                              clock_marker,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_level,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dda_pkg::LEN_W-1:0]         cfg_data
);

    logic [dda_pkg::LEN_W-1:0] frame_length_reg;
    logic [dda_pkg::LEN_W-1:0] frame_length_next;

    logic                 front_valid;
    logic                 front_ready;
    dda_pkg::cmd_t        front_cmd;
    logic                 q_valid;
    logic                 q_ready;
    dda_pkg::cmd_t        q_cmd;
    dda_pkg::q_status_t   q_status;

    // The configuration register is always ready to take a beat.
    assign cfg_ready         = 1'b1;
    assign frame_length_next = (cfg_valid && cfg_ready) ? cfg_data : frame_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= dda_pkg::FRAME_LENGTH_RESET;
        end
        else
        begin
            frame_length_reg <= frame_length_next;
        end
    end

    // Front part: decode each input beat into a tick or a push command.
    dda_front u_front
    (
        .action     (action),
        .enable     (enable),
        .preset     (preset),
        .step_value (step_value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd_valid  (front_valid),
        .cmd        (front_cmd),
        .cmd_ready  (front_ready)
    );

    // Command queue between the two parts.
    dda_cmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd),
        .status   (q_status)
    );

    // Back part: executes one command per cycle into the result register, unless a waiting result is stalled.
    dda_back
    #(
        .FIFO_DEPTH    (FIFO_DEPTH),
        .PRESCALE_WRAP (PRESCALE_WRAP)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_length (frame_length_reg),
        .cmd_valid    (q_valid),
        .cmd_ready    (q_ready),
        .cmd          (q_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pulse_out    (pulse_out),
        .frame_flag   (frame_flag),
        .clock_marker (clock_marker),
        .fifo_level   (fifo_level)
    );

`ifndef SYNTHESIS
    // The FIFO level never passes the FIFO depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fifo_level <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH)))
        else $error("fifo_level exceeds the FIFO depth");

    // The input side is held off only when the command queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_status.full)
        else $error("in_ready low while the command queue has room");

    // A queued command reaches an empty result register in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && !out_valid) |=> out_valid)
        else $error("queued command not executed into a free result register");
`endif

endmodule

// File: verif/tb_dda_step_pulse_generator.sv
// Self-checking testbench for the DDA step-pulse generator.
`timescale 1ns / 1ps

module tb_dda_step_pulse_generator;

    localparam int FIFO_DEPTH    = 10;
    localparam int PRESCALE_WRAP = 100;
    localparam int LEVEL_W       = $clog2(FIFO_DEPTH + 1);
    localparam int DIR_ROWS      = 25;
    localparam int STEP_W        = dda_pkg::STEP_W;
    localparam int LEN_W         = dda_pkg::LEN_W;
    localparam int POS_W         = dda_pkg::POS_W;
    localparam int ACC_W         = dda_pkg::ACC_W;
    localparam int AS_W          = dda_pkg::ACT_STEP_W;
    localparam logic [6:0] PS_WRAP = 7'(PRESCALE_WRAP);
    localparam logic [6:0] PS_HALF = 7'(PRESCALE_WRAP / 2);
    // An input passes the command queue and then the result register, so a handful of
    // quiet cycles is ample before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 8;
    // The run sends some six hundred beats, each costing at most a sender
    // gap plus a receiver stall; this limit is many times that.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    // One result beat as the block presents it.
    typedef struct packed {
        logic               pulse;
        logic               flag;
        logic               marker;
        logic [LEVEL_W-1:0] level;
    } gen_out_t;

    // One row of the directed stimulus. Where known is set, want holds the
    // result read straight off the behaviour; otherwise the predictor decides.
    typedef struct packed {
        logic              act;
        logic              en;
        logic              pre;
        logic [STEP_W-1:0] val;
        logic              known;
        gen_out_t          want;
    } dir_row_t;

    // ------------------------------------------------------------------
    // Signals to and from the block. Every input has a known value at
    // time zero; after that they only change at rising edges.
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               action       = dda_pkg::ACTION_TICK;
    logic               enable       = 1'b0;
    logic               preset       = 1'b0;
    logic [STEP_W-1:0]  step_value   = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               pulse_out;
    logic               frame_flag;
    logic               clock_marker;
    logic [LEVEL_W-1:0] fifo_level;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data     = '0;

    dda_step_pulse_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .enable       (enable),
        .preset       (preset),
        .step_value   (step_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pulse_out    (pulse_out),
        .frame_flag   (frame_flag),
        .clock_marker (clock_marker),
        .fifo_level   (fifo_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the generator, starting from the
    // post-reset values. It is advanced once per accepted input beat.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]      reg_frame_len = dda_pkg::FRAME_LENGTH_RESET;
    logic [6:0]            ps_count      = '0;
    logic                  half_low      = 1'b0;
    logic                  marker_state  = 1'b0;
    logic                  pulse_armed   = 1'b0;
    logic                  pulse_state   = 1'b0;
    logic                  flag_state    = 1'b0;
    logic [POS_W-1:0]      frame_pos     = '0;
    logic [LEN_W-1:0]      cur_len       = dda_pkg::FRAME_LENGTH_RESET;
    logic [AS_W-1:0]       cur_step      = '0;
    logic [ACC_W-1:0]      acc_sum       = '0;
    logic [STEP_W-1:0]     step_queue [FIFO_DEPTH] = '{default: '0};
    int                    queue_fill    = 0;

    // Results still owed by the block, oldest first.
    gen_out_t expected_outputs [$];

    int mismatches      = 0;
    int ticks_sent      = 0;
    int pushes_sent     = 0;
    int cfg_writes      = 0;
    int results_checked = 0;
    int pulses_seen     = 0;
    int markers_seen    = 0;
    int cycle_count     = 0;
    int burst_left      = 0;

    // Directed stimulus. The first rows run from the reset state, so their
    // results are plain: a push repeats the cleared tick outputs alongside
    // the new level, and the early ticks sit in the low phase of the
    // prescaler inside the first half of the frame. The FIFO is then filled
    // and pushed once more while full, which must overwrite the tail and
    // leave the level at ten. The closing ticks reach the half-frame point,
    // where the 255 at the head is popped and clamped to ten.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b0, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd1}},
        '{dda_pkg::ACTION_PUSH, 1'b1, 1'b1, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd2}},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 4'd2}},
        '{dda_pkg::ACTION_TICK, 1'b0, 1'b0, 8'hFF, 1'b1, '{1'b0, 1'b1, 1'b0, 4'd2}},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b1, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 4'd2}},
        '{dda_pkg::ACTION_TICK, 1'b0, 1'b1, 8'hA5, 1'b1, '{1'b0, 1'b1, 1'b0, 4'd2}},
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b0, 8'd11,  1'b1, '{1'b0, 1'b1, 1'b0, 4'd3}},
        '{dda_pkg::ACTION_PUSH, 1'b1, 1'b0, 8'd10,  1'b1, '{1'b0, 1'b1, 1'b0, 4'd4}},
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b1, 8'd1,   1'b1, '{1'b0, 1'b1, 1'b0, 4'd5}},
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b0, 8'd2,   1'b1, '{1'b0, 1'b1, 1'b0, 4'd6}},
        '{dda_pkg::ACTION_PUSH, 1'b1, 1'b1, 8'd3,   1'b1, '{1'b0, 1'b1, 1'b0, 4'd7}},
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b0, 8'd4,   1'b1, '{1'b0, 1'b1, 1'b0, 4'd8}},
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b0, 8'd5,   1'b1, '{1'b0, 1'b1, 1'b0, 4'd9}},
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b0, 8'd6,   1'b1, '{1'b0, 1'b1, 1'b0, 4'd10}},
        '{dda_pkg::ACTION_PUSH, 1'b0, 1'b0, 8'd200, 1'b1, '{1'b0, 1'b1, 1'b0, 4'd10}},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b1, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{dda_pkg::ACTION_TICK, 1'b1, 1'b0, 8'h00, 1'b0, '0}
    };

    // Advances the predicted generator by one input beat and returns the
    // result that beat must produce.
    function automatic gen_out_t advance_generator(logic act, logic en, logic pre,
                                                   logic [STEP_W-1:0] val);
        logic [ACC_W:0]    sum;
        logic [STEP_W-1:0] head;
        gen_out_t          res;
        int                i;
        if (act == dda_pkg::ACTION_PUSH)
        begin
            // A push into a full FIFO lands on the last entry instead.
            if (queue_fill < FIFO_DEPTH)
                queue_fill++;
            step_queue[queue_fill - 1] = val;
        end
        else
        begin
            if (en && !pre)
            begin
                ps_count = (ps_count == PS_WRAP) ? '0 : ps_count + 7'd1;
                half_low = (ps_count <= PS_HALF);
                if (ps_count == PS_HALF)
                    marker_state = 1'b1;
                else if (ps_count == PS_WRAP)
                    marker_state = 1'b0;
                // The pulse armed on the previous tick shows only in the high phase.
                pulse_state = !half_low && pulse_armed;
            end
            else
            begin
                pulse_state  = 1'b0;
                marker_state = 1'b0;
            end

            frame_pos++;
            flag_state = (frame_pos <= {1'b0, cur_len});
            if (frame_pos == {1'b0, cur_len} || frame_pos == {cur_len, 1'b0})
            begin
                head     = (queue_fill > 0) ? step_queue[0] : '0;
                cur_len  = reg_frame_len;
                cur_step = (head > STEP_W'(dda_pkg::STEP_CLAMP)) ? dda_pkg::STEP_CLAMP
                                                                 : head[AS_W-1:0];
                for (i = 0; i < FIFO_DEPTH - 1; i++)
                    step_queue[i] = step_queue[i + 1];
                step_queue[FIFO_DEPTH - 1] = '0;
                if (queue_fill > 0)
                    queue_fill--;
            end
            // The wrap test uses the length just reloaded, if any.
            if (frame_pos >= {cur_len, 1'b0})
                frame_pos = '0;

            sum = {1'b0, acc_sum} + (ACC_W+1)'(cur_step);
            if (sum > {1'b0, dda_pkg::ACC_MAX})
                sum = {1'b0, dda_pkg::ACC_MAX};
            if (sum >= (ACC_W+1)'(cur_len))
            begin
                sum         = sum - (ACC_W+1)'(cur_len);
                pulse_armed = 1'b1;
            end
            else
                pulse_armed = 1'b0;
            acc_sum = sum[ACC_W-1:0];
        end
        res.pulse  = pulse_state;
        res.flag   = flag_state;
        res.marker = marker_state;
        res.level  = queue_fill[LEVEL_W-1:0];
        return res;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Offers one input beat and waits for it to be taken. The sender works
    // in bursts: when a burst is used up, valid drops for a random gap and a
    // fresh burst length is drawn. Valid is never lowered once raised for a
    // beat, and the payload holds until the handshake.
    task automatic send_beat(logic act, logic en, logic pre, logic [STEP_W-1:0] val,
                             logic known, gen_out_t want);
        gen_out_t predicted;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid   <= 1'b1;
        action     <= act;
        enable     <= en;
        preset     <= pre;
        step_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (act == dda_pkg::ACTION_PUSH)
            pushes_sent++;
        else
            ticks_sent++;
        predicted = advance_generator(act, en, pre, val);
        expected_outputs.push_back(known ? want : predicted);
    endtask

    // Stops offering beats and waits until every owed result has come back,
    // then lets the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the frame length register; only ever called with the block idle.
    task automatic write_frame_length(logic [LEN_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_frame_len = len;
        cfg_writes++;
    endtask

    // Random beats for one register setting. Mostly running ticks, so that
    // the prescaler climbs through its marker points, with pushes mixed in
    // at the given rate and the odd stopped or preset tick. The phase runs
    // on until the new length has been taken up by a pop, and halfway
    // through the sender holds off until the block has caught up.
    task automatic run_random_beats(int min_beats, int push_pct);
        int                n;
        int                pick;
        logic [STEP_W-1:0] val;
        n = 0;
        while (n < min_beats || cur_len != reg_frame_len)
        begin
            if (n == min_beats / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            // Small counts sit around the clamp boundary of ten.
            val  = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom_range(0, 12))
                                               : STEP_W'($urandom_range(0, 255));
            if (pick < push_pct)
                send_beat(dda_pkg::ACTION_PUSH, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), val, 1'b0, '0);
            else if (pick < 88)
                send_beat(dda_pkg::ACTION_TICK, 1'b1, 1'b0, val, 1'b0, '0);
            else
                send_beat(dda_pkg::ACTION_TICK, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), val, 1'b0, '0);
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: out_ready follows a pattern of its own, switching every so
    // often between always ready, mostly ready, mostly stalled and a fixed
    // three-in-five rhythm.
    // ------------------------------------------------------------------
    int sink_mode  = 0;
    int sink_timer = 0;
    int sink_tick  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (sink_timer == 0)
            begin
                sink_mode  = $urandom_range(0, 3);
                sink_timer = $urandom_range(20, 120);
            end
            sink_timer--;
            sink_tick++;
            case (sink_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 9) < 4);
                default: out_ready <= ((sink_tick % 5) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result beat is matched against the oldest
    // owed result, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        gen_out_t seen;
        gen_out_t due;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{pulse_out, frame_flag, clock_marker, fifo_level};
            if (expected_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result beat with nothing owed: %p", $time, seen);
            end
            else
            begin
                due = expected_outputs.pop_front();
                if (seen.pulse !== due.pulse)
                    note_mismatch("pulse_out", int'(due.pulse), int'(seen.pulse));
                if (seen.flag !== due.flag)
                    note_mismatch("frame_flag", int'(due.flag), int'(seen.flag));
                if (seen.marker !== due.marker)
                    note_mismatch("clock_marker", int'(due.marker), int'(seen.marker));
                if (seen.level !== due.level)
                    note_mismatch("fifo_level", int'(due.level), int'(seen.level));
            end
            results_checked++;
            if (seen.pulse === 1'b1)
                pulses_seen++;
            if (seen.marker === 1'b1)
                markers_seen++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results owed",
                     cycle_count, expected_outputs.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        logic [LEN_W-1:0] small_lengths [5];
        // Reset is held low from time zero and released once, at an edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].act, directed_rows[i].en, directed_rows[i].pre,
                      directed_rows[i].val, directed_rows[i].known, directed_rows[i].want);
        drain_results();

        // Short frames first: a length of one pops on every tick, the
        // longer ones let the FIFO fill up and overflow.
        small_lengths = '{LEN_W'(1), LEN_W'(2), LEN_W'(7), LEN_W'(13),
                          LEN_W'($urandom_range(3, 30))};
        foreach (small_lengths[i])
        begin
            write_frame_length(small_lengths[i]);
            run_random_beats(70, 25);
            drain_results();
        end

        // A longer frame. Once taken up, the position has to run up to the
        // new length before the next pop, so the zero length written after
        // it is picked up only after a stretch of ticks. A zero length
        // freezes the frame for good, so it comes last.
        write_frame_length(LEN_W'(200));
        run_random_beats(40, 10);
        drain_results();
        write_frame_length('0);
        run_random_beats(40, 5);
        drain_results();

        $display("Sent %0d ticks and %0d pushes across %0d frame length settings.",
                 ticks_sent, pushes_sent, cfg_writes + 1);
        $display("Checked %0d results: %0d with a step pulse, %0d with the marker raised.",
                 results_checked, pulses_seen, markers_seen);
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
